// File: hdl/mlcr_pkg.sv
// ----------------------------------------------------------------------------
// mlcr_pkg
// shared constants, types and the arctangent table for the camera turn block
// ----------------------------------------------------------------------------
package mlcr_pkg;

    localparam int SCREEN_WIDTH  = 1280;
    localparam int SCREEN_HEIGHT = 720;

    localparam int CORDIC_STEPS = 16;

    // angles in units of 2^-16 rad
    localparam logic signed [21:0] TWO_PI_ANG  = 22'sd411775;
    localparam logic signed [21:0] PI_ANG      = 22'sd205887;
    localparam logic signed [21:0] HALF_PI_ANG = 22'sd102944;
    localparam logic signed [18:0] CORDIC_GAIN = 19'sd39797;

    localparam logic [2:0] REG_SENSITIVITY   = 3'd0;
    localparam logic [2:0] REG_START_DIR_X   = 3'd1;
    localparam logic [2:0] REG_START_DIR_Y   = 3'd2;
    localparam logic [2:0] REG_START_PLANE_X = 3'd3;
    localparam logic [2:0] REG_START_PLANE_Y = 3'd4;

    localparam logic FUNC_POINTER = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    localparam logic        [15:0] RST_SENSITIVITY   = 16'd12583;
    localparam logic signed [15:0] RST_START_DIR_X   = 16'sd16384;
    localparam logic signed [15:0] RST_START_DIR_Y   = 16'sd0;
    localparam logic signed [15:0] RST_START_PLANE_X = 16'sd0;
    localparam logic signed [15:0] RST_START_PLANE_Y = 16'sd10813;

    localparam logic signed [15:0] UNIT_POS = 16'sd16384;
    localparam logic signed [15:0] UNIT_NEG = -16'sd16384;

    typedef struct packed {
        logic en;
        logic first;
    } mac_ctl_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] sin_v;
        logic signed [15:0] cos_v;
    } trig_t;

    function automatic logic [15:0] atan_entry(input logic [3:0] idx);
        logic [15:0] v;
        unique case (idx)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/mlcr_mac.sv
// ----------------------------------------------------------------------------
// mlcr_mac
// shared signed multiplier with registered product and accumulator
// ----------------------------------------------------------------------------
module mlcr_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  mlcr_pkg::mac_ctl_t  ctl,
    input  logic signed [15:0]  op_a,
    input  logic signed [16:0]  op_b,
    output logic signed [33:0]  acc
);

    logic signed [32:0] prod_reg;
    logic signed [33:0] acc_reg;
    logic               en_reg;
    logic               first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            first_reg <= 1'b0;
            prod_reg  <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            en_reg    <= ctl.en;
            first_reg <= ctl.first;
            prod_reg  <= 33'(op_a) * 33'(op_b);
            if (en_reg)
            begin
                if (first_reg)
                    acc_reg <= 34'(prod_reg);
                else
                    acc_reg <= acc_reg + 34'(prod_reg);
            end
        end
    end

    assign acc = acc_reg;

endmodule

// File: hdl/mlcr_cordic.sv
// ----------------------------------------------------------------------------
// mlcr_cordic
// iterative sin and cos: range reduction, quadrant fold, 16 rotation steps
// ----------------------------------------------------------------------------
module mlcr_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [21:0]  angle,
    output mlcr_pkg::trig_t     res
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_REDUCE,
        C_ROT,
        C_FIN
    } cstate_t;

    cstate_t            state_reg;
    logic signed [21:0] r_reg;
    logic signed [19:0] z_reg;
    logic signed [18:0] x_reg;
    logic signed [18:0] y_reg;
    logic [3:0]         i_reg;
    logic               neg_reg;
    logic               done_reg;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;

    logic signed [21:0] fold;
    logic               fold_neg;
    logic signed [18:0] xs;
    logic signed [18:0] ys;
    logic signed [19:0] atan_v;
    logic signed [18:0] xr;
    logic signed [18:0] yr;
    logic signed [15:0] xc;
    logic signed [15:0] yc;

    always_comb
    begin
        fold     = r_reg;
        fold_neg = 1'b0;
        if (r_reg > mlcr_pkg::HALF_PI_ANG)
        begin
            fold     = r_reg - mlcr_pkg::PI_ANG;
            fold_neg = 1'b1;
        end
        else if (r_reg < -mlcr_pkg::HALF_PI_ANG)
        begin
            fold     = r_reg + mlcr_pkg::PI_ANG;
            fold_neg = 1'b1;
        end
        xs     = x_reg >>> i_reg;
        ys     = y_reg >>> i_reg;
        atan_v = signed'({4'b0000, mlcr_pkg::atan_entry(i_reg)});
        xr     = (x_reg + 19'sd2) >>> 2;
        yr     = (y_reg + 19'sd2) >>> 2;
        if (xr > 19'(mlcr_pkg::UNIT_POS))
            xc = mlcr_pkg::UNIT_POS;
        else if (xr < 19'(mlcr_pkg::UNIT_NEG))
            xc = mlcr_pkg::UNIT_NEG;
        else
            xc = 16'(xr);
        if (yr > 19'(mlcr_pkg::UNIT_POS))
            yc = mlcr_pkg::UNIT_POS;
        else if (yr < 19'(mlcr_pkg::UNIT_NEG))
            yc = mlcr_pkg::UNIT_NEG;
        else
            yc = 16'(yr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            r_reg     <= '0;
            z_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            i_reg     <= '0;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
            sin_reg   <= '0;
            cos_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        r_reg     <= angle;
                        state_reg <= C_REDUCE;
                    end
                end
                C_REDUCE:
                begin
                    if (r_reg > mlcr_pkg::PI_ANG)
                        r_reg <= r_reg - mlcr_pkg::TWO_PI_ANG;
                    else if (r_reg < -mlcr_pkg::PI_ANG)
                        r_reg <= r_reg + mlcr_pkg::TWO_PI_ANG;
                    else
                    begin
                        z_reg     <= 20'(fold);
                        neg_reg   <= fold_neg;
                        x_reg     <= mlcr_pkg::CORDIC_GAIN;
                        y_reg     <= '0;
                        i_reg     <= '0;
                        state_reg <= C_ROT;
                    end
                end
                C_ROT:
                begin
                    if (z_reg >= 20'sd0)
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_v;
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_v;
                    end
                    if (i_reg == 4'(mlcr_pkg::CORDIC_STEPS - 1))
                        state_reg <= C_FIN;
                    else
                        i_reg <= i_reg + 4'd1;
                end
                C_FIN:
                begin
                    cos_reg   <= neg_reg ? -xc : xc;
                    sin_reg   <= neg_reg ? -yc : yc;
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign res.done  = done_reg;
    assign res.sin_v = sin_reg;
    assign res.cos_v = cos_reg;

endmodule

// File: hdl/mouse_look_camera_rotate.sv
// ----------------------------------------------------------------------------
// mouse_look_camera_rotate
// pointer-driven camera turn: yaw rotation of direction and plane, pitch clamp
// ----------------------------------------------------------------------------
// channel   signals                                         direction
// in        in_valid, in_stall, func, pointer_x, pointer_y  item in
// out       out_valid, out_stall, facing_*, view_plane_*,   item out
//           tilt
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data       register write
//
// a pointer item passes from accept to out_valid through the yaw and pitch-step
// products, the cordic (range reduction plus 16 rotation steps) and the shared
// multiplier for the eight rotation products; a restart item loads the start
// pose and zero pitch and goes straight to out_valid
// one item at a time; in_stall stays high until the result item is taken
// reset loads the start pose reset values and zero pitch; cfg_ready is always high
// ----------------------------------------------------------------------------
module mouse_look_camera_rotate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic signed [12:0]  pointer_x,
    input  logic signed [12:0]  pointer_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  facing_x,
    output logic signed [15:0]  facing_y,
    output logic signed [15:0]  view_plane_x,
    output logic signed [15:0]  view_plane_y,
    output logic signed [15:0]  tilt,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_YAW,
        S_TURN,
        S_MIX,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic [3:0]         cnt_reg;
    logic signed [15:0] dx2_reg;
    logic signed [15:0] dy2_reg;
    logic signed [15:0] dir_x_reg;
    logic signed [15:0] dir_y_reg;
    logic signed [15:0] plane_x_reg;
    logic signed [15:0] plane_y_reg;
    logic signed [15:0] pitch_reg;
    logic               out_valid_reg;

    logic        [15:0] sens_reg;
    logic signed [15:0] start_dir_x_reg;
    logic signed [15:0] start_dir_y_reg;
    logic signed [15:0] start_plane_x_reg;
    logic signed [15:0] start_plane_y_reg;

    mlcr_pkg::mac_ctl_t mac_ctl;
    logic signed [15:0] mac_a;
    logic signed [16:0] mac_b;
    logic signed [33:0] mac_acc;
    mlcr_pkg::trig_t    trig;
    logic               cordic_start;
    logic signed [21:0] yaw;

    logic               accept;
    logic signed [33:0] yaw_wide;
    logic signed [33:0] step_wide;
    logic signed [20:0] pitch_sum;
    logic signed [15:0] pitch_new;
    logic signed [33:0] mix_wide;
    logic signed [15:0] mix_val;
    logic [1:0]         mix_k;
    logic               mix_first;
    logic signed [15:0] neg_sin;
    logic signed [15:0] dx2_in;
    logic signed [15:0] dy2_in;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        dx2_in    = signed'({{2{pointer_x[12]}}, pointer_x, 1'b0})
                    - 16'sd1 * 16'(mlcr_pkg::SCREEN_WIDTH);
        dy2_in    = signed'({{2{pointer_y[12]}}, pointer_y, 1'b0})
                    - 16'sd1 * 16'(mlcr_pkg::SCREEN_HEIGHT);
        yaw_wide  = (mac_acc + 34'sd256) >>> 9;
        step_wide = (mac_acc + 34'sd1024) >>> 11;
        yaw       = signed'(yaw_wide[21:0]);
        pitch_sum = 21'(pitch_reg) + signed'(step_wide[20:0]);
        if (pitch_sum > 21'(mlcr_pkg::UNIT_POS))
            pitch_new = mlcr_pkg::UNIT_POS;
        else if (pitch_sum < 21'(mlcr_pkg::UNIT_NEG))
            pitch_new = mlcr_pkg::UNIT_NEG;
        else
            pitch_new = 16'(pitch_sum);
        mix_wide = (mac_acc + 34'sd8192) >>> 14;
        if (mix_wide > 34'sd32767)
            mix_val = 16'sh7fff;
        else if (mix_wide < -34'sd32768)
            mix_val = 16'sh8000;
        else
            mix_val = 16'(mix_wide);

        mix_k     = cnt_reg[2:1];
        mix_first = !cnt_reg[0];
        neg_sin   = -trig.sin_v;

        mac_ctl.en    = 1'b0;
        mac_ctl.first = 1'b1;
        mac_a         = dx2_reg;
        mac_b         = signed'({1'b0, sens_reg});
        cordic_start  = 1'b0;
        if (state_reg == S_YAW)
        begin
            mac_ctl.en   = (cnt_reg < 4'd2);
            mac_a        = (cnt_reg == 4'd0) ? dx2_reg : dy2_reg;
            cordic_start = (cnt_reg == 4'd2);
        end
        else if (state_reg == S_MIX)
        begin
            mac_ctl.en    = (cnt_reg < 4'd8);
            mac_ctl.first = mix_first;
            if (mix_k[1])
                mac_a = mix_first ? plane_x_reg : plane_y_reg;
            else
                mac_a = mix_first ? dir_x_reg : dir_y_reg;
            if (mix_k[0])
                mac_b = 17'(mix_first ? trig.sin_v : trig.cos_v);
            else
                mac_b = 17'(mix_first ? trig.cos_v : neg_sin);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg          <= mlcr_pkg::RST_SENSITIVITY;
            start_dir_x_reg   <= mlcr_pkg::RST_START_DIR_X;
            start_dir_y_reg   <= mlcr_pkg::RST_START_DIR_Y;
            start_plane_x_reg <= mlcr_pkg::RST_START_PLANE_X;
            start_plane_y_reg <= mlcr_pkg::RST_START_PLANE_Y;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mlcr_pkg::REG_SENSITIVITY:   sens_reg          <= cfg_data;
                mlcr_pkg::REG_START_DIR_X:   start_dir_x_reg   <= signed'(cfg_data);
                mlcr_pkg::REG_START_DIR_Y:   start_dir_y_reg   <= signed'(cfg_data);
                mlcr_pkg::REG_START_PLANE_X: start_plane_x_reg <= signed'(cfg_data);
                mlcr_pkg::REG_START_PLANE_Y: start_plane_y_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            dx2_reg       <= '0;
            dy2_reg       <= '0;
            dir_x_reg     <= mlcr_pkg::RST_START_DIR_X;
            dir_y_reg     <= mlcr_pkg::RST_START_DIR_Y;
            plane_x_reg   <= mlcr_pkg::RST_START_PLANE_X;
            plane_y_reg   <= mlcr_pkg::RST_START_PLANE_Y;
            pitch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (func == mlcr_pkg::FUNC_RESTART)
                        begin
                            dir_x_reg     <= start_dir_x_reg;
                            dir_y_reg     <= start_dir_y_reg;
                            plane_x_reg   <= start_plane_x_reg;
                            plane_y_reg   <= start_plane_y_reg;
                            pitch_reg     <= '0;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            dx2_reg   <= dx2_in;
                            dy2_reg   <= dy2_in;
                            cnt_reg   <= '0;
                            state_reg <= S_YAW;
                        end
                    end
                end
                S_YAW:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd3)
                    begin
                        pitch_reg <= pitch_new;
                        state_reg <= S_TURN;
                    end
                end
                S_TURN:
                begin
                    if (trig.done)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MIX;
                    end
                end
                S_MIX:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    unique case (cnt_reg)
                        4'd3:    dir_x_reg   <= mix_val;
                        4'd5:    dir_y_reg   <= mix_val;
                        4'd7:    plane_x_reg <= mix_val;
                        4'd9:    plane_y_reg <= mix_val;
                        default: ;
                    endcase
                    if (cnt_reg == 4'd9)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    mlcr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (mac_acc)
    );

    mlcr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (yaw),
        .res   (trig)
    );

    assign out_valid    = out_valid_reg;
    assign facing_x     = dir_x_reg;
    assign facing_y     = dir_y_reg;
    assign view_plane_x = plane_x_reg;
    assign view_plane_y = plane_y_reg;
    assign tilt         = pitch_reg;

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench for mouse_look_camera_rotate
// drives pointer and restart items with random idle and stall on both sides,
// reprograms sensitivity and start pose between runs of items, and checks
// every returned pose against an in-bench fixed-point camera turn predictor
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TWO_PI_Q16  = 411775;
    localparam longint PI_Q16      = 205887;
    localparam longint HALF_PI_Q16 = 102944;
    localparam longint GAIN_Q16    = 39797;
    localparam int     ROT_STEPS   = 16;
    localparam longint ARCTAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                           256, 128, 64, 32, 16, 8, 4, 2};

    localparam logic [2:0] REG_UNMAPPED = mlcr_pkg::REG_START_PLANE_Y + 3'd1;
    localparam logic signed [12:0] PIX_MIN = 13'h1000;
    localparam logic signed [12:0] PIX_MAX = 13'h0FFF;

    typedef struct {
        logic signed [15:0] facing_x;
        logic signed [15:0] facing_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
        logic signed [15:0] tilt;
    } pose_t;

    class pose_scoreboard;
        longint sensitivity;
        longint start_dir_x, start_dir_y, start_plane_x, start_plane_y;
        longint dir_x, dir_y, plane_x, plane_y, pitch;
        pose_t  expected_poses[$];
        int     errors;

        function new();
            sensitivity   = 12583;
            start_dir_x   = 16384;
            start_dir_y   = 0;
            start_plane_x = 0;
            start_plane_y = 10813;
            dir_x   = start_dir_x;
            dir_y   = start_dir_y;
            plane_x = start_plane_x;
            plane_y = start_plane_y;
            pitch   = 0;
            errors  = 0;
        endfunction

        function longint bound(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint mix(longint a, longint ka, longint b, longint kb);
            return bound((a * ka + b * kb + 8192) >>> 14, -32768, 32767);
        endfunction

        function void sin_cos(input longint ang, output longint s, output longint c);
            longint r, x, y, z, xs, ys;
            bit flip;
            r = ang % TWO_PI_Q16;
            flip = 1'b0;
            if (r > PI_Q16) r -= TWO_PI_Q16;
            if (r < -PI_Q16) r += TWO_PI_Q16;
            if (r > HALF_PI_Q16)
            begin
                r -= PI_Q16;
                flip = 1'b1;
            end
            else if (r < -HALF_PI_Q16)
            begin
                r += PI_Q16;
                flip = 1'b1;
            end
            x = GAIN_Q16;
            y = 0;
            z = r;
            for (int i = 0; i < ROT_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x -= ys;
                    y += xs;
                    z -= ARCTAN_Q16[i];
                end
                else
                begin
                    x += ys;
                    y -= xs;
                    z += ARCTAN_Q16[i];
                end
            end
            x = bound((x + 2) >>> 2, -16384, 16384);
            y = bound((y + 2) >>> 2, -16384, 16384);
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_config(logic [2:0] idx, logic [15:0] value);
            case (idx)
                mlcr_pkg::REG_SENSITIVITY:   sensitivity   = longint'(value);
                mlcr_pkg::REG_START_DIR_X:   start_dir_x   = longint'($signed(value));
                mlcr_pkg::REG_START_DIR_Y:   start_dir_y   = longint'($signed(value));
                mlcr_pkg::REG_START_PLANE_X: start_plane_x = longint'($signed(value));
                mlcr_pkg::REG_START_PLANE_Y: start_plane_y = longint'($signed(value));
                default: ;
            endcase
        endfunction

        function void note_item(logic f, logic signed [12:0] x, logic signed [12:0] y);
            longint dx2, dy2, yaw, pstep, s, c, nx;
            pose_t p;
            if (f == mlcr_pkg::FUNC_RESTART)
            begin
                dir_x   = start_dir_x;
                dir_y   = start_dir_y;
                plane_x = start_plane_x;
                plane_y = start_plane_y;
                pitch   = 0;
            end
            else
            begin
                dx2   = 2 * longint'(x) - mlcr_pkg::SCREEN_WIDTH;
                dy2   = 2 * longint'(y) - mlcr_pkg::SCREEN_HEIGHT;
                yaw   = (dx2 * sensitivity + 256) >>> 9;
                pstep = (dy2 * sensitivity + 1024) >>> 11;
                sin_cos(yaw, s, c);
                nx      = mix(dir_x, c, dir_y, -s);
                dir_y   = mix(dir_x, s, dir_y, c);
                dir_x   = nx;
                nx      = mix(plane_x, c, plane_y, -s);
                plane_y = mix(plane_x, s, plane_y, c);
                plane_x = nx;
                pitch   = bound(pitch + pstep, -16384, 16384);
            end
            p.facing_x = 16'(dir_x);
            p.facing_y = 16'(dir_y);
            p.plane_x  = 16'(plane_x);
            p.plane_y  = 16'(plane_y);
            p.tilt     = 16'(pitch);
            expected_poses.push_back(p);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_pose(logic signed [15:0] fx, logic signed [15:0] fy,
                        logic signed [15:0] plx, logic signed [15:0] ply,
                        logic signed [15:0] tl);
            pose_t want;
            if (expected_poses.size() == 0)
            begin
                report("result item with no expectation");
                return;
            end
            want = expected_poses.pop_front();
            if (fx !== want.facing_x)
                report($sformatf("facing_x got %0d want %0d", fx, want.facing_x));
            if (fy !== want.facing_y)
                report($sformatf("facing_y got %0d want %0d", fy, want.facing_y));
            if (plx !== want.plane_x)
                report($sformatf("view_plane_x got %0d want %0d", plx, want.plane_x));
            if (ply !== want.plane_y)
                report($sformatf("view_plane_y got %0d want %0d", ply, want.plane_y));
            if (tl !== want.tilt)
                report($sformatf("tilt got %0d want %0d", tl, want.tilt));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               func = mlcr_pkg::FUNC_POINTER;
    logic signed [12:0] pointer_x = '0;
    logic signed [12:0] pointer_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] facing_x;
    logic signed [15:0] facing_y;
    logic signed [15:0] view_plane_x;
    logic signed [15:0] view_plane_y;
    logic signed [15:0] tilt;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    int send_idle_pct  = 32;
    int recv_stall_pct = 56;

    pose_scoreboard board = new();

    mouse_look_camera_rotate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .pointer_x    (pointer_x),
        .pointer_y    (pointer_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .facing_x     (facing_x),
        .facing_y     (facing_y),
        .view_plane_x (view_plane_x),
        .view_plane_y (view_plane_y),
        .tilt         (tilt),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("mouse_look_camera_rotate verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_pose(facing_x, facing_y, view_plane_x, view_plane_y, tilt);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_item(input logic f, input logic signed [12:0] x,
                             input logic signed [12:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        pointer_x <= x;
        pointer_y <= y;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(f, x, y);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.expected_poses.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.note_config(idx, value);
    endtask

    task automatic program_regs(input logic [15:0] sens, input logic [15:0] dx,
                                input logic [15:0] dy, input logic [15:0] plx,
                                input logic [15:0] ply);
        drain();
        write_reg(mlcr_pkg::REG_SENSITIVITY, sens);
        write_reg(mlcr_pkg::REG_START_DIR_X, dx);
        write_reg(mlcr_pkg::REG_START_DIR_Y, dy);
        write_reg(mlcr_pkg::REG_START_PLANE_X, plx);
        write_reg(mlcr_pkg::REG_START_PLANE_Y, ply);
        write_reg(REG_UNMAPPED + 3'($urandom_range(2)), 16'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_items();
        send_item(mlcr_pkg::FUNC_POINTER, 13'(mlcr_pkg::SCREEN_WIDTH / 2),
                  13'(mlcr_pkg::SCREEN_HEIGHT / 2));
        send_item(mlcr_pkg::FUNC_POINTER, PIX_MAX, PIX_MAX);
        send_item(mlcr_pkg::FUNC_POINTER, PIX_MIN, PIX_MIN);
        send_item(mlcr_pkg::FUNC_POINTER, PIX_MAX, PIX_MIN);
        send_item(mlcr_pkg::FUNC_POINTER, PIX_MIN, PIX_MAX);
        // pointer fields of a restart are don't-care
        send_item(mlcr_pkg::FUNC_RESTART, PIX_MAX, PIX_MIN);
        repeat (3) send_item(mlcr_pkg::FUNC_POINTER, 13'(mlcr_pkg::SCREEN_WIDTH / 2 + 1),
                             PIX_MAX);
        repeat (3) send_item(mlcr_pkg::FUNC_POINTER, 13'(mlcr_pkg::SCREEN_WIDTH / 2 - 1),
                             PIX_MIN);
        // new start pose stays dormant until the restart
        program_regs(16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_item(mlcr_pkg::FUNC_POINTER, 13'(mlcr_pkg::SCREEN_WIDTH / 2 + 60),
                  13'(mlcr_pkg::SCREEN_HEIGHT / 2));
        send_item(mlcr_pkg::FUNC_RESTART, 13'($urandom), 13'($urandom));
        repeat (3) send_item(mlcr_pkg::FUNC_POINTER, 13'($urandom), 13'($urandom));
        program_regs(16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_item(mlcr_pkg::FUNC_RESTART, 13'($urandom), 13'($urandom));
        send_item(mlcr_pkg::FUNC_POINTER, PIX_MAX, PIX_MAX);
        send_item(mlcr_pkg::FUNC_POINTER, PIX_MIN, PIX_MIN);
    endtask

    task automatic random_setup();
        logic [15:0] sens;
        case ($urandom_range(2))
            0: sens = 16'($urandom);
            1: sens = 16'($urandom_range(20000));
            default: sens = 16'($urandom_range(255));
        endcase
        if ($urandom_range(1))
            program_regs(sens, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
            program_regs(sens, mlcr_pkg::RST_START_DIR_X, mlcr_pkg::RST_START_DIR_Y,
                         mlcr_pkg::RST_START_PLANE_X, mlcr_pkg::RST_START_PLANE_Y);
        send_item(mlcr_pkg::FUNC_RESTART, 13'($urandom), 13'($urandom));
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            send_item(mlcr_pkg::FUNC_RESTART, 13'($urandom), 13'($urandom));
        else if (pick < 50)
            send_item(mlcr_pkg::FUNC_POINTER,
                      13'($urandom_range(mlcr_pkg::SCREEN_WIDTH - 1)),
                      13'($urandom_range(mlcr_pkg::SCREEN_HEIGHT - 1)));
        else if (pick < 75)
            send_item(mlcr_pkg::FUNC_POINTER,
                      13'(mlcr_pkg::SCREEN_WIDTH / 2 - 8 + $urandom_range(16)),
                      13'(mlcr_pkg::SCREEN_HEIGHT / 2 - 8 + $urandom_range(16)));
        else
            send_item(mlcr_pkg::FUNC_POINTER, 13'($urandom), 13'($urandom));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 56;
                end
                1:
                begin
                    send_idle_pct  = 56;
                    recv_stall_pct = 32;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                random_setup();
                repeat (58) random_item();
            end
        end
        drain();
        repeat (48) @(posedge clk);
        if (board.expected_poses.size() != 0)
            board.report("expected item never arrived");
        if (board.errors == 0)
            $display("mouse_look_camera_rotate verification clean");
        else
            $display("mouse_look_camera_rotate verification failed");
        $finish;
    end

endmodule
